// File: rtl/core/byte_ring_fifo_peek_discard_core_macros.svh
// assertion macros shared by the fifo core
// each macro is compiled away when ASSERT_OFF is defined
`ifndef BYTE_RING_FIFO_PEEK_DISCARD_CORE_MACROS_SVH
`define BYTE_RING_FIFO_PEEK_DISCARD_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define BRFPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define BRFPD_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define BRFPD_ASSERT(lbl, clk, rst, prop)
`define BRFPD_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: rtl/core/brfpd_pkg.sv
`default_nettype none

package brfpd_pkg;

  // store geometry
  localparam int STORE_DEPTH    = 4096;
  localparam int MAX_READ_BYTES = 4;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 12;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // derived widths
  localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WIDE_W = ((PTR_W > FIELD_W) ? PTR_W : FIELD_W) + 1;
  localparam int GN_W   = $clog2(MAX_READ_BYTES + 1);
  localparam int GI_W   = (MAX_READ_BYTES > 1) ? $clog2(MAX_READ_BYTES) : 1;
  localparam int GD_W   = MAX_READ_BYTES * BYTE_W;
  localparam int GDX_W  = (GD_W > DATA_W) ? GD_W : DATA_W;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t LAST_SLOT = ptr_t'(STORE_DEPTH - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_DISCARD = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

  // pointer advance modulo the depth, amt below the depth
  function automatic ptr_t ptr_add(ptr_t p, ptr_t amt);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, amt};
    if (s >= (PTR_W+1)'(STORE_DEPTH)) begin
      s = s - (PTR_W+1)'(STORE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // bytes held between the two pointers
  function automatic ptr_t ptr_fill(ptr_t wp, ptr_t rp);
    logic [PTR_W:0] d;
    d = {1'b0, wp} - {1'b0, rp};
    if (d[PTR_W]) begin
      d = d + (PTR_W+1)'(STORE_DEPTH);
    end
    return d[PTR_W-1:0];
  endfunction

  // pointer-sized value onto a 12-bit result field
  function automatic logic [FIELD_W-1:0] to_field(ptr_t v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/brfpd_ram.sv
`default_nettype none

module brfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/byte_ring_fifo_peek_discard_core.sv
// channel | direction | handshake           | payload
// in      | into core | in_valid / in_ready   | operation, write_byte, count, offset
// out     | from core | out_valid / out_ready | read_data, bytes_done, status,
//         |           |                       | fill_count, free_count, is_empty_flag,
//         |           |                       | is_full_flag
//
// one item at a time: write, discard, clear, unknown codes and empty reads or peeks pass
// through S_CALC and S_FINISH into the result register, a read or peek also S_GATHER,
// as the single read port gathers one byte a cycle; in_ready returns on publish
// the store is never cleared: only slots between the pointers are ever read
// rst (synchronous, active high) zeroes both pointers and empties the result register
// a stalled result holds in the output register; the next beat is still taken
// and waits at the end of its work until the register is free
`default_nettype none

`include "byte_ring_fifo_peek_discard_core_macros.svh"

module byte_ring_fifo_peek_discard_core
  import brfpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [BYTE_W-1:0]   write_byte,
  input  wire logic [FIELD_W-1:0]  count,
  input  wire logic [FIELD_W-1:0]  offset,
  // result channel
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [DATA_W-1:0]   read_data,
  output      logic [FIELD_W-1:0]  bytes_done,
  output      logic [STATUS_W-1:0] status,
  output      logic [FIELD_W-1:0]  fill_count,
  output      logic [FIELD_W-1:0]  free_count,
  output      logic                is_empty_flag,
  output      logic                is_full_flag
);

  // sequencer: take beat, decide and update pointers, gather bytes, publish
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_GATHER = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // ring pointers
  ptr_t rd_ptr, wr_ptr;

  // latched request
  logic [OP_W-1:0]    op_q;
  logic [BYTE_W-1:0]  wbyte_q;
  logic [FIELD_W-1:0] count_q;
  logic [FIELD_W-1:0] offset_q;

  // result under construction
  logic [FIELD_W-1:0]  done_q;
  logic [STATUS_W-1:0] status_q;

  // gather engine
  logic [GN_W-1:0]   gather_n;
  logic [GN_W-1:0]   iss_cnt;
  logic [GN_W-1:0]   rcv_cnt;
  logic              rd_pend;
  ptr_t              base_addr;
  logic [BYTE_W-1:0] gather_bytes [MAX_READ_BYTES];
  logic [GD_W-1:0]   gather_flat;
  logic [GDX_W-1:0]  gather_wide;

  // store port
  logic              ram_we;
  ptr_t              ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // decision logic, valid in S_CALC
  ptr_t              fill_now;
  logic [WIDE_W-1:0] count_w, fill_w, off_sel, avail;
  logic [GN_W-1:0]   want, gn;
  ptr_t              base_calc, disc_amt;
  logic              issue, last_rcv, out_free;

  assign fill_now = ptr_fill(wr_ptr, rd_ptr);
  assign count_w  = WIDE_W'(count_q);
  assign fill_w   = WIDE_W'(fill_now);
  assign off_sel  = (op_q == OP_PEEK) ? WIDE_W'(offset_q) : '0;
  assign avail    = fill_w - off_sel;

  // request clipped to the widest read
  assign want = (count_w > WIDE_W'(MAX_READ_BYTES)) ? GN_W'(MAX_READ_BYTES)
                                                     : count_q[GN_W-1:0];

  // bytes that actually exist past the offset
  always_comb begin
    if (off_sel >= fill_w) begin
      gn = '0;
    end else if (avail < WIDE_W'(want)) begin
      gn = avail[GN_W-1:0];
    end else begin
      gn = want;
    end
  end

  assign base_calc = ptr_add(rd_ptr, off_sel[PTR_W-1:0]);
  assign disc_amt  = (count_w < fill_w) ? count_w[PTR_W-1:0] : fill_now;

  // one read issued per cycle, data lands the next cycle
  assign issue     = (state == S_GATHER) && (iss_cnt < gather_n);
  assign ram_raddr = ptr_add(base_addr, ptr_t'(iss_cnt));
  assign last_rcv  = rd_pend && (rcv_cnt == GN_W'(gather_n - GN_W'(1)));
  assign ram_we    = (state == S_CALC) && (op_q == OP_WRITE) && (fill_now != LAST_SLOT);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    for (int i = 0; i < MAX_READ_BYTES; i++) begin
      gather_flat[i*BYTE_W +: BYTE_W] = gather_bytes[i];
    end
    gather_wide = GDX_W'(gather_flat);
  end

  brfpd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (wbyte_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if ((op_q == OP_READ || op_q == OP_PEEK) && gn != '0) begin
          state_next = S_GATHER;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_GATHER: begin
        if (last_rcv) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (state == S_CALC) begin
        case (op_q)
          OP_WRITE: begin
            if (fill_now != LAST_SLOT) begin
              wr_ptr <= ptr_add(wr_ptr, ptr_t'(1));
            end
          end
          OP_READ:    rd_ptr <= ptr_add(rd_ptr, ptr_t'(gn));
          OP_DISCARD: rd_ptr <= ptr_add(rd_ptr, disc_amt);
          OP_CLEAR: begin
            rd_ptr <= '0;
            wr_ptr <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= operation;
      wbyte_q  <= write_byte;
      count_q  <= count;
      offset_q <= offset;
    end

    if (state == S_CALC) begin
      done_q   <= '0;
      status_q <= ST_OK;
      gather_n <= '0;
      iss_cnt  <= '0;
      rcv_cnt  <= '0;
      base_addr <= base_calc;
      for (int i = 0; i < MAX_READ_BYTES; i++) begin
        gather_bytes[i] <= '0;
      end
      case (op_q)
        OP_WRITE: begin
          if (fill_now == LAST_SLOT) begin
            status_q <= ST_NO_SPACE;
          end else begin
            done_q <= FIELD_W'(1);
          end
        end
        OP_READ, OP_PEEK: begin
          done_q   <= FIELD_W'(gn);
          gather_n <= gn;
          if (gn < want) begin
            status_q <= ST_SHORT;
          end
        end
        OP_DISCARD: done_q <= to_field(disc_amt);
        default: ;
      endcase
    end

    if (issue) begin
      iss_cnt <= iss_cnt + GN_W'(1);
    end
    if (state == S_GATHER && rd_pend) begin
      gather_bytes[rcv_cnt[GI_W-1:0]] <= ram_rdata;
      rcv_cnt <= rcv_cnt + GN_W'(1);
    end

    // publish, pointers already reflect this beat
    if (state == S_FINISH && out_free) begin
      read_data     <= gather_wide[DATA_W-1:0];
      bytes_done    <= done_q;
      status        <= status_q;
      fill_count    <= to_field(fill_now);
      free_count    <= to_field(LAST_SLOT - fill_now);
      is_empty_flag <= (fill_now == '0);
      is_full_flag  <= (fill_now == LAST_SLOT);
    end
  end

  // an accepted beat always goes straight to the decision cycle
  `BRFPD_ASSERT(a_accept_to_calc, clk, rst, (in_valid && in_ready) |=> (state == S_CALC))
  // pointers stay inside the store
  `BRFPD_ASSERT_NEVER(a_ptr_range, clk, rst, (rd_ptr > LAST_SLOT) || (wr_ptr > LAST_SLOT))
  // never more bytes received than the gather asked for
  `BRFPD_ASSERT_NEVER(a_rcv_bound, clk, rst, (state == S_GATHER) && ((rcv_cnt > gather_n) || (iss_cnt > gather_n)))
  // a refused write reports nothing done
  `BRFPD_ASSERT(a_nospace_zero, clk, rst, (out_valid && status == ST_NO_SPACE) |-> (bytes_done == '0))

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import brfpd_pkg::*;

  // opcodes the core leaves undecoded
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // the ring keeps one slot empty
  localparam int unsigned MAX_HELD = STORE_DEPTH - 1;

  localparam int unsigned RANDOM_ITEMS  = 1350;
  localparam int unsigned LIGHT_IDLE    = 12;
  localparam int unsigned HEAVY_IDLE    = 49;
  localparam int unsigned SHOWN_ERRORS  = 10;
  // longer than the longest gather of MAX_READ_BYTES bytes, so this is plenty
  localparam int unsigned DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  wbyte;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] offs;
  } fifo_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [FIELD_W-1:0]  done;
    logic [STATUS_W-1:0] stat;
    logic [FIELD_W-1:0]  fill;
    logic [FIELD_W-1:0]  space;
    logic                empty;
    logic                full;
  } fifo_res_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation  = '0;
  logic [BYTE_W-1:0]   write_byte = '0;
  logic [FIELD_W-1:0]  count      = '0;
  logic [FIELD_W-1:0]  offset     = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [DATA_W-1:0]   read_data;
  logic [FIELD_W-1:0]  bytes_done;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  fill_count;
  logic [FIELD_W-1:0]  free_count;
  logic                is_empty_flag;
  logic                is_full_flag;

  byte_ring_fifo_peek_discard_core dut (.*);

  // beats waiting to be driven, and the results they are due to produce
  fifo_req_t   req_backlog[$];
  fifo_res_t   due_results[$];
  fifo_req_t   on_bus;

  int unsigned total_items    = 0;
  int unsigned beats_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;

  // fill level as the stimulus plans it, only used to aim offsets and counts
  int unsigned plan_fill = 0;

  // shadow copy of the ring: byte store and both pointers
  logic [BYTE_W-1:0] ring_img [STORE_DEPTH];
  ptr_t              head_ptr = '0;
  ptr_t              tail_ptr = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned held_bytes();
    return (int'(tail_ptr) + STORE_DEPTH - int'(head_ptr)) % STORE_DEPTH;
  endfunction

  // apply one accepted beat to the shadow ring and queue the result it owes
  function automatic void fifo_apply(fifo_req_t r);
    fifo_res_t   e;
    int unsigned held, want, start, n, i;
    e = '0;
    e.stat = ST_OK;
    held = held_bytes();
    case (r.op)
      OP_WRITE: begin
        if (held >= MAX_HELD) begin
          e.stat = ST_NO_SPACE;
        end else begin
          ring_img[tail_ptr] = r.wbyte;
          tail_ptr = ptr_t'((tail_ptr + 1) % STORE_DEPTH);
          e.done = FIELD_W'(1);
        end
      end
      OP_READ, OP_PEEK: begin
        // requests are clipped to the widest gather
        want = (r.len > MAX_READ_BYTES) ? MAX_READ_BYTES : r.len;
        start = (r.op == OP_PEEK) ? r.offs : 0;
        n = (start >= held) ? 0 : held - start;
        if (n > want) n = want;
        // oldest byte lands in the lowest lane
        for (i = 0; i < n; i++) begin
          e.data[BYTE_W*i +: BYTE_W] = ring_img[ptr_t'((head_ptr + start + i) % STORE_DEPTH)];
        end
        e.done = FIELD_W'(n);
        if (n < want) e.stat = ST_SHORT;
        if (r.op == OP_READ) head_ptr = ptr_t'((head_ptr + n) % STORE_DEPTH);
      end
      OP_DISCARD: begin
        n = (r.len < held) ? r.len : held;
        e.done = FIELD_W'(n);
        head_ptr = ptr_t'((head_ptr + n) % STORE_DEPTH);
      end
      OP_CLEAR: begin
        head_ptr = '0;
        tail_ptr = '0;
      end
      default: ;
    endcase
    held = held_bytes();
    e.fill  = FIELD_W'(held);
    e.space = FIELD_W'(MAX_HELD - held);
    e.empty = (held == 0);
    e.full  = (held == MAX_HELD);
    due_results.push_back(e);
  endfunction

  function automatic void add_req(logic [OP_W-1:0] op, logic [BYTE_W-1:0] wb,
                                  logic [FIELD_W-1:0] len, logic [FIELD_W-1:0] offs);
    int unsigned take;
    req_backlog.push_back(fifo_req_t'{op, wb, len, offs});
    case (op)
      OP_WRITE: if (plan_fill < MAX_HELD) plan_fill++;
      OP_READ: begin
        take = (len < MAX_READ_BYTES) ? len : MAX_READ_BYTES;
        plan_fill -= (take < plan_fill) ? take : plan_fill;
      end
      OP_DISCARD: plan_fill -= (len < plan_fill) ? len : plan_fill;
      OP_CLEAR: plan_fill = 0;
      default: ;
    endcase
  endfunction

  // mostly legal widths, some zero, some past the limit, some anything
  function automatic logic [FIELD_W-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 70) return FIELD_W'($urandom_range(MAX_READ_BYTES, 1));
    if (roll < 80) return '0;
    if (roll < 90) return FIELD_W'($urandom_range(16, MAX_READ_BYTES + 1));
    return FIELD_W'($urandom);
  endfunction

  // three idling phases: light sender / heavy receiver, swapped, then none
  function automatic int unsigned idle_pct(int unsigned progress, bit sender);
    if (progress * 3 < total_items) return sender ? LIGHT_IDLE : HEAVY_IDLE;
    if (progress * 3 < total_items * 2) return sender ? HEAVY_IDLE : LIGHT_IDLE;
    return 0;
  endfunction

  // driver: a beat holds until taken, then the next one may follow at once
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fifo_apply(on_bus);
        beats_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 &&
            $urandom_range(99, 0) >= idle_pct(beats_accepted, 1'b1)) begin
          on_bus = req_backlog.pop_front();
          operation  <= on_bus.op;
          write_byte <= on_bus.wbyte;
          count      <= on_bus.len;
          offset     <= on_bus.offs;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result beat against the oldest outstanding expectation
  always @(posedge clk) begin
    fifo_res_t seen_res, want_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_res = {read_data, bytes_done, status, fill_count, free_count,
                    is_empty_flag, is_full_flag};
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("result %0d came with nothing outstanding: data %h done %0d status %0d",
                     results_seen, seen_res.data, seen_res.done, seen_res.stat);
          end
        end else begin
          want_res = due_results.pop_front();
          if (seen_res.data !== want_res.data || seen_res.done !== want_res.done ||
              seen_res.stat !== want_res.stat || seen_res.fill !== want_res.fill ||
              seen_res.space !== want_res.space || seen_res.empty !== want_res.empty ||
              seen_res.full !== want_res.full) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
              $display("result %0d wrong: expected data %h done %0d status %0d",
                       results_seen, want_res.data, want_res.done, want_res.stat);
              $display("  expected fill %0d free %0d empty %b full %b",
                       want_res.fill, want_res.space, want_res.empty, want_res.full);
              $display("  actual data %h done %0d status %0d",
                       seen_res.data, seen_res.done, seen_res.stat);
              $display("  actual fill %0d free %0d empty %b full %b",
                       seen_res.fill, seen_res.space, seen_res.empty, seen_res.full);
            end
          end
        end
      end
      out_ready <= $urandom_range(99, 0) >= idle_pct(results_seen, 1'b0);
    end
  end

  initial begin
    int unsigned mixed, roll, pick, burst;
    logic [BYTE_W-1:0]  wb;
    logic [FIELD_W-1:0] len, offs;

    // directed: empty ring first
    add_req(OP_READ, 8'h00, 12'd4, 12'd0);
    add_req(OP_PEEK, 8'hff, 12'd4, 12'd0);
    add_req(OP_DISCARD, 8'h00, 12'hfff, 12'hfff);
    // extreme bytes
    add_req(OP_WRITE, 8'h00, 12'd0, 12'd0);
    add_req(OP_WRITE, 8'hff, 12'hfff, 12'hfff);
    add_req(OP_WRITE, 8'ha5, 12'd0, 12'd0);
    add_req(OP_WRITE, 8'h5a, 12'd0, 12'd0);
    // zero length read, zero length peek past the end
    add_req(OP_READ, 8'h00, 12'd0, 12'd0);
    add_req(OP_PEEK, 8'h00, 12'd0, 12'd4);
    // full width peek, clipped over-long peek, peek past the end, single byte
    add_req(OP_PEEK, 8'h00, 12'd4, 12'd0);
    add_req(OP_PEEK, 8'h00, 12'hfff, 12'd1);
    add_req(OP_PEEK, 8'h00, 12'd4, 12'hfff);
    add_req(OP_PEEK, 8'h00, 12'd1, 12'd3);
    // pop two, then ask for more than remains
    add_req(OP_READ, 8'h00, 12'd2, 12'd0);
    add_req(OP_READ, 8'h00, 12'hfff, 12'd0);
    // discard some, then more than held
    add_req(OP_WRITE, 8'h3c, 12'd0, 12'd0);
    add_req(OP_WRITE, 8'hc3, 12'd0, 12'd0);
    add_req(OP_WRITE, 8'h81, 12'd0, 12'd0);
    add_req(OP_DISCARD, 8'h00, 12'd1, 12'd0);
    add_req(OP_DISCARD, 8'h00, 12'hfff, 12'd0);
    // clear with something held
    add_req(OP_WRITE, 8'h7e, 12'd0, 12'd0);
    add_req(OP_CLEAR, 8'hff, 12'hfff, 12'hfff);
    // undecoded opcodes with noise on every field
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
      add_req(OP_W'(c), BYTE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    end

    // random mix; unused fields always carry noise
    for (mixed = 0; mixed < RANDOM_ITEMS; mixed++) begin
      roll = $urandom_range(99, 0);
      pick = $urandom_range(99, 0);
      wb   = BYTE_W'($urandom);
      len  = FIELD_W'($urandom);
      offs = FIELD_W'($urandom);
      if (roll < 1) begin
        // short write burst to lift the fill level
        burst = $urandom_range(24, 4);
        repeat (burst) begin
          add_req(OP_WRITE, BYTE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end
      end else if (roll < 50) begin
        add_req(OP_WRITE, wb, len, offs);
      end else if (roll < 66) begin
        add_req(OP_READ, wb, pick_len(), offs);
      end else if (roll < 84) begin
        // offsets aimed around the held bytes, so both hits and misses occur
        if (pick < 75) offs = FIELD_W'($urandom_range(plan_fill + 2, 0));
        else if (pick < 90) offs = FIELD_W'($urandom_range(15, 0));
        add_req(OP_PEEK, wb, pick_len(), offs);
      end else if (roll < 93) begin
        if (pick < 60) len = FIELD_W'($urandom_range(6, 0));
        else if (pick < 85) len = FIELD_W'($urandom_range(plan_fill + 3, 0));
        add_req(OP_DISCARD, wb, len, offs);
      end else if (roll < 96) begin
        add_req(OP_CLEAR, wb, len, offs);
      end else begin
        add_req(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), wb, len, offs);
      end
    end
    total_items = req_backlog.size();

    // reset held from the start, then released
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (beats_accepted != total_items) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // catch any stray result beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: byte_ring_fifo_peek_discard_core.f
+incdir+rtl/core
rtl/core/brfpd_pkg.sv
rtl/core/brfpd_ram.sv
rtl/core/byte_ring_fifo_peek_discard_core.sv
test/tb_top.sv
